>>> rtl/dltq_pkg.sv
package dltq_pkg;

    localparam int DELTA_W    = 32;
    localparam int TASK_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int MAX_OUT    = 16;
    localparam int SLOTS_DEF  = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);

    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_ZERO     = 2'd1,
        ST_FULL     = 2'd2,
        ST_EXPIRED  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ_CMP,
        S_W_NEW,
        S_W_SUCC,
        S_W_PREV,
        S_TK_HEAD,
        S_TK_NEXT,
        S_EMIT
    } t_state;

endpackage

>>> rtl/dltq_ram.sv
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/delta_list_timer_queue_core.sv
// delta-list timer queue
// input stream: one word per command. tuser = command (1 = tick, 0 = delay
// request); tdata = delay ticks in the low 32 bits, task id above.
// output stream: one word per result. tuser = status, tdata = slot index in
// bits 3:0 and task id in bits 11:4; tlast marks the final word of a command.
// a delay request gives exactly one word. it takes one compare per list
// entry visited and one to three slot-memory writes; a rejected request
// goes straight to its word. the walk through the slot memory (one write port,
// one read port) goes one entry per cycle through one shared subtractor.
// a tick on an empty list, or one whose head does not expire, gives no word;
// otherwise one word per expired entry (at most 16), one per cycle while the
// receiver takes them.
// tready is high only while the sequencer is idle, one command at a time.
// a finished word waits in the output register; when the receiver stalls,
// a tick with several expiries holds its walk until the register drains.
// reset empties the list and frees every slot; no clearing pass is needed.
module delta_list_timer_queue_core #(
    parameter int SLOTS = dltq_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [dltq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // delay_ticks, task_id
    input  logic                            i_s_axis_tuser,  // command
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [dltq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // slot_index, woken_task
    output logic [dltq_pkg::STATUS_W-1:0]   o_m_axis_tuser,  // status
    output logic                            o_m_axis_tlast
);

    import dltq_pkg::*;

    localparam int SW     = $clog2(SLOTS);
    localparam int STEP_W = $clog2(SLOTS + 1);
    localparam int T_LO   = DELTA_W;
    localparam int N_LO   = DELTA_W + TASK_W;
    localparam int H_BIT  = N_LO + SW;
    localparam int EW     = H_BIT + 1;
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(SLOTS);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_OUT);

    t_state                r_state, n_state;
    logic [SLOTS-1:0]      r_free, n_free;
    logic [SW-1:0]         r_head, n_head;
    logic                  r_nonempty, n_nonempty;
    logic [DELTA_W-1:0]    r_d, n_d;
    logic [TASK_W-1:0]     r_task, n_task;
    logic [SW-1:0]         r_slot, n_slot;
    logic [SW-1:0]         r_cur, n_cur;
    logic [SW-1:0]         r_prev_idx, n_prev_idx;
    logic [EW-1:0]         r_prev, n_prev;
    logic [EW-1:0]         r_succ, n_succ;
    logic                  r_have, n_have;
    logic                  r_have_prev, n_have_prev;
    logic [STEP_W-1:0]     r_steps, n_steps;
    logic [CNT_W-1:0]      r_exp_cnt, n_exp_cnt;
    t_status               r_pend_status, n_pend_status;
    logic [SW-1:0]         r_pend_slot, n_pend_slot;
    logic [TASK_W-1:0]     r_pend_task, n_pend_task;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [TASK_W-1:0]     r_out_task;
    logic                  r_out_last;

    logic               ram_we;
    logic [SW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_wdata;
    logic [SW-1:0]      ram_raddr;
    logic [EW-1:0]      rd_entry;
    logic [DELTA_W-1:0] rd_delta;
    logic [TASK_W-1:0]  rd_task;
    logic [SW-1:0]      rd_next;
    logic               rd_has_next;

    logic [DELTA_W-1:0] sub_a, sub_b;
    logic [DELTA_W:0]   sub_res;
    logic               sub_borrow;

    logic               in_accept;
    logic               out_free;
    logic               out_load;
    logic               out_last;
    logic [SW-1:0]      free_top;
    logic [SW+SLOT_OUT_W-1:0] pend_slot_ext;

    dltq_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    assign rd_delta    = rd_entry[DELTA_W-1:0];
    assign rd_task     = rd_entry[N_LO-1:T_LO];
    assign rd_next     = rd_entry[H_BIT-1:N_LO];
    assign rd_has_next = rd_entry[H_BIT];

    // shared subtract and compare unit
    assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_res[DELTA_W];

    always_comb begin
        free_top = '0;
        for (int b = 0; b < SLOTS; b++) begin
            if (r_free[b]) begin
                free_top = SW'(b);
            end
        end
    end

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign pend_slot_ext   = {{SLOT_OUT_W{1'b0}}, r_pend_slot};

    always_comb begin
        n_state       = r_state;
        n_free        = r_free;
        n_head        = r_head;
        n_nonempty    = r_nonempty;
        n_d           = r_d;
        n_task        = r_task;
        n_slot        = r_slot;
        n_cur         = r_cur;
        n_prev_idx    = r_prev_idx;
        n_prev        = r_prev;
        n_succ        = r_succ;
        n_have        = r_have;
        n_have_prev   = r_have_prev;
        n_steps       = r_steps;
        n_exp_cnt     = r_exp_cnt;
        n_pend_status = r_pend_status;
        n_pend_slot   = r_pend_slot;
        n_pend_task   = r_pend_task;
        ram_we        = 1'b0;
        ram_waddr     = r_slot;
        ram_wdata     = {r_have, r_cur, r_task, r_d};
        ram_raddr     = r_head;
        sub_a         = r_d;
        sub_b         = rd_delta;
        out_load      = 1'b0;
        out_last      = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_task = i_s_axis_tdata[IN_DATA_W-1:DELTA_W];
                    n_d    = i_s_axis_tdata[DELTA_W-1:0];
                    if (i_s_axis_tuser == CMD_TICK) begin
                        if (r_nonempty) begin
                            n_state = S_TK_HEAD;
                        end
                    end else if (i_s_axis_tdata[DELTA_W-1:0] == '0) begin
                        n_pend_status = ST_ZERO;
                        n_pend_slot   = '0;
                        n_pend_task   = i_s_axis_tdata[IN_DATA_W-1:DELTA_W];
                        n_state       = S_EMIT;
                    end else if (r_free == '0) begin
                        n_pend_status = ST_FULL;
                        n_pend_slot   = '0;
                        n_pend_task   = i_s_axis_tdata[IN_DATA_W-1:DELTA_W];
                        n_state       = S_EMIT;
                    end else begin
                        n_slot           = free_top;
                        n_free[free_top] = 1'b0;
                        n_cur            = r_head;
                        n_have           = r_nonempty;
                        n_have_prev      = 1'b0;
                        n_steps          = '0;
                        n_state          = r_nonempty ? S_REQ_CMP : S_W_NEW;
                    end
                end
            end
            S_REQ_CMP: begin
                sub_a = r_d;
                sub_b = rd_delta;
                if (r_steps < STEP_MAX && !sub_borrow) begin
                    n_d         = sub_res[DELTA_W-1:0];
                    n_prev      = rd_entry;
                    n_prev_idx  = r_cur;
                    n_have_prev = 1'b1;
                    n_have      = rd_has_next;
                    n_cur       = rd_next;
                    n_steps     = r_steps + 1'b1;
                    ram_raddr   = rd_next;
                    if (!rd_has_next) begin
                        n_state = S_W_NEW;
                    end
                end else begin
                    n_succ  = rd_entry;
                    n_state = S_W_NEW;
                end
            end
            S_W_NEW: begin
                ram_we        = 1'b1;
                ram_waddr     = r_slot;
                ram_wdata     = {r_have, r_cur, r_task, r_d};
                n_pend_status = ST_ACCEPTED;
                n_pend_slot   = r_slot;
                n_pend_task   = r_task;
                if (!r_have_prev) begin
                    n_head     = r_slot;
                    n_nonempty = 1'b1;
                end
                if (r_have) begin
                    n_state = S_W_SUCC;
                end else if (r_have_prev) begin
                    n_state = S_W_PREV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_W_SUCC: begin
                sub_a     = r_succ[DELTA_W-1:0];
                sub_b     = r_d;
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                ram_wdata = {r_succ[EW-1:DELTA_W], sub_res[DELTA_W-1:0]};
                n_state   = r_have_prev ? S_W_PREV : S_EMIT;
            end
            S_W_PREV: begin
                ram_we    = 1'b1;
                ram_waddr = r_prev_idx;
                ram_wdata = {1'b1, r_slot, r_prev[N_LO-1:0]};
                n_state   = S_EMIT;
            end
            S_TK_HEAD: begin
                sub_a = rd_delta;
                sub_b = DELTA_W'(1);
                if (rd_delta != '0 && sub_res[DELTA_W-1:0] != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_head;
                    ram_wdata = {rd_entry[EW-1:DELTA_W], sub_res[DELTA_W-1:0]};
                    n_state   = S_IDLE;
                end else begin
                    n_pend_status  = ST_EXPIRED;
                    n_pend_slot    = r_head;
                    n_pend_task    = rd_task;
                    n_free[r_head] = 1'b1;
                    n_nonempty     = rd_has_next;
                    n_head         = rd_next;
                    n_exp_cnt      = CNT_W'(1);
                    ram_raddr      = rd_next;
                    n_state        = rd_has_next ? S_TK_NEXT : S_EMIT;
                end
            end
            S_TK_NEXT: begin
                ram_raddr = r_head;
                if (rd_delta != '0) begin
                    n_state = S_EMIT;
                end else if (out_free) begin
                    out_load       = 1'b1;
                    out_last       = 1'b0;
                    n_pend_status  = ST_EXPIRED;
                    n_pend_slot    = r_head;
                    n_pend_task    = rd_task;
                    n_free[r_head] = 1'b1;
                    n_nonempty     = rd_has_next;
                    n_head         = rd_next;
                    n_exp_cnt      = r_exp_cnt + 1'b1;
                    ram_raddr      = rd_next;
                    if (!rd_has_next || n_exp_cnt >= CNT_MAX) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '1;
            r_head      <= '0;
            r_nonempty  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free     <= n_free;
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d           <= n_d;
        r_task        <= n_task;
        r_slot        <= n_slot;
        r_cur         <= n_cur;
        r_prev_idx    <= n_prev_idx;
        r_prev        <= n_prev;
        r_succ        <= n_succ;
        r_have        <= n_have;
        r_have_prev   <= n_have_prev;
        r_steps       <= n_steps;
        r_exp_cnt     <= n_exp_cnt;
        r_pend_status <= n_pend_status;
        r_pend_slot   <= n_pend_slot;
        r_pend_task   <= n_pend_task;
        if (out_load) begin
            r_out_status <= r_pend_status;
            r_out_slot   <= pend_slot_ext[SLOT_OUT_W-1:0];
            r_out_task   <= r_pend_task;
            r_out_last   <= out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - TASK_W - SLOT_OUT_W){1'b0}}, r_out_task,
                              r_out_slot};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_empty_all_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_nonempty) |-> (r_free == '1))
        else $error("empty list with slots still taken");

    a_head_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_nonempty) |-> !r_free[r_head])
        else $error("list head marked free");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REQ_CMP) |-> (r_steps < STEP_MAX))
        else $error("insertion walk ran past the pool size");

    a_expiry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_NEXT) |-> (r_exp_cnt < CNT_MAX && r_exp_cnt != '0))
        else $error("expiry count out of range");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_task)))
        else $error("output word overwritten while stalled");
`endif

endmodule
